// ===== rtl/ialu_pkg.sv =====
`default_nettype none
package ialu_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  // work kinds after classification; subtract is folded into add
  localparam logic [2:0] K_ADD  = 3'd0;
  localparam logic [2:0] K_MUL  = 3'd1;
  localparam logic [2:0] K_DIV  = 3'd2;
  localparam logic [2:0] K_REM  = 3'd3;
  localparam logic [2:0] K_DVZ  = 3'd4;
  localparam logic [2:0] K_NONE = 3'd5;

  localparam int unsigned W = 64;
  localparam int unsigned HW = 32;

  typedef struct packed {
    logic [2:0]   kind;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } ialu_op_t;

endpackage
`default_nettype wire

// ===== rtl/ialu_front.sv =====
`default_nettype none
module ialu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        action,
  input  wire logic [63:0]       operand_a,
  input  wire logic [63:0]       operand_b,
  output logic                   op_valid,
  input  wire logic              op_ready,
  output ialu_pkg::ialu_op_t     op
);
  import ialu_pkg::*;

  ialu_op_t op_next;

  always_comb begin
    op_next.a = operand_a;
    op_next.b = operand_b;
    op_next.kind = K_NONE;
    case (action)
      OP_ADD: op_next.kind = K_ADD;
      OP_SUB: begin
        op_next.kind = K_ADD;
        op_next.b = ~operand_b + 64'd1;
      end
      OP_MUL: op_next.kind = K_MUL;
      OP_DIV: op_next.kind = (operand_b == '0) ? K_DVZ : K_DIV;
      OP_REM: op_next.kind = (operand_b == '0) ? K_DVZ : K_REM;
      default: op_next.kind = K_NONE;
    endcase
  end

  assign in_ready = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op <= op_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ialu_queue.sv =====
`default_nettype none
module ialu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire ialu_pkg::ialu_op_t push_op,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output ialu_pkg::ialu_op_t     pop_op
);
  import ialu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ialu_op_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push, pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_op = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_op;
  end

endmodule
`default_nettype wire

// ===== rtl/ialu_div.sv =====
`default_nettype none
module ialu_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        want_rem,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      quot_rem
);
  import ialu_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_DONE = 2'd2;

  logic [1:0]   state;
  logic [5:0]   cnt;
  logic [W-1:0] rem, quo, mb;
  logic         a_neg, b_neg, rem_sel;
  logic [W:0]   diff;

  // restoring step: shift in next dividend bit, try subtract
  assign diff = {rem, quo[W-1]} - {1'b0, mb};
  assign done = state == D_DONE;

  always_comb begin
    if (rem_sel) quot_rem = a_neg ? ~rem + 64'd1 : rem;
    else         quot_rem = (a_neg ^ b_neg) ? ~quo + 64'd1 : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        D_IDLE: if (start) begin
          state <= D_RUN;
          cnt   <= '0;
        end
        D_RUN: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= D_DONE;
        end
        D_DONE: state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == D_IDLE && start) begin
      a_neg   <= a[W-1];
      b_neg   <= b[W-1];
      rem_sel <= want_rem;
      quo     <= a[W-1] ? ~a + 64'd1 : a;
      mb      <= b[W-1] ? ~b + 64'd1 : b;
      rem     <= '0;
    end else if (state == D_RUN) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ialu_back.sv =====
`default_nettype none
module ialu_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               op_valid,
  output logic                    op_ready,
  input  wire ialu_pkg::ialu_op_t op,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             result,
  output logic                    div_by_zero
);
  import ialu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]    state;
  logic          pop;
  logic          out_valid_next;
  logic [W-1:0]  p0;
  logic [HW-1:0] p1, p2;
  logic          div_done;
  logic [W-1:0]  div_res;

  assign op_ready = state == S_IDLE && (!out_valid || out_ready);
  assign pop = op_valid && op_ready;

  ialu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (pop && (op.kind == K_DIV || op.kind == K_REM)),
    .want_rem (op.kind == K_REM),
    .a        (op.a),
    .b        (op.b),
    .done     (div_done),
    .quot_rem (div_res)
  );

  // kinds other than multiply and divide finish at pop; multiply and divide finish from their states
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if ((state == S_IDLE && pop && !(op.kind inside {K_MUL, K_DIV, K_REM})) ||
        state == S_MUL || (state == S_DIV && div_done)) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: if (pop) begin
          case (op.kind)
            K_MUL: state <= S_MUL;
            K_DIV, K_REM: state <= S_DIV;
            default: state <= S_IDLE;
          endcase
        end
        S_MUL: state <= S_IDLE;
        S_DIV: if (div_done) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p0 <= op.a[HW-1:0] * op.b[HW-1:0];
      p1 <= HW'(op.a[HW-1:0] * op.b[W-1:HW]);
      p2 <= HW'(op.a[W-1:HW] * op.b[HW-1:0]);
      div_by_zero <= op.kind == K_DVZ;
      case (op.kind)
        K_ADD:   result <= op.a + op.b;
        default: result <= '0;
      endcase
    end else if (state == S_MUL) begin
      result <= p0 + {p1 + p2, {HW{1'b0}}};
    end else if (state == S_DIV && div_done) begin
      result <= div_res;
    end
  end

`ifndef SYNTHESIS
  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !out_valid)
    else $error("output slot occupied while unit busy");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished with no divide pending");
  a_mul_one: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> state == S_IDLE && out_valid)
    else $error("multiply did not complete in one step");
`endif

endmodule
`default_nettype wire

// ===== rtl/int64_alu_add_sub_mul_div_mod.sv =====
// channel  dir  handshake          tdata                         tuser
// s_axis   in   s_tvalid/s_tready  [63:0] operand_a [127:64] b   [2:0] action
// m_axis   out  m_tvalid/m_tready  [63:0] result                 [0] div_by_zero
//
// Add, subtract, unused codes and zero divisor: result registered at pop, no busy state in the back end.
// Multiply: three 32x32 partial products registered at pop, then one add in the S_MUL state.
// Divide/remainder: one-bit-per-cycle restoring divider; the back end takes no new beat until it is done.
// Front register and a QDEPTH-entry queue keep accepting beats while the back is busy, until both are full.
// rst is synchronous and clears handshake state only; results come out in order.
`default_nettype none
module int64_alu_add_sub_mul_div_mod #(
  parameter int unsigned QDEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // operand_a, operand_b
  input  wire logic [2:0]   s_tuser,   // action
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,   // result
  output logic              m_tuser    // div_by_zero
);
  import ialu_pkg::*;

  logic     f_valid, f_ready, q_valid, q_ready;
  ialu_op_t f_op, q_op;

  ialu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .action    (s_tuser),
    .operand_a (s_tdata[63:0]),
    .operand_b (s_tdata[127:64]),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  ialu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  ialu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (q_valid),
    .op_ready    (q_ready),
    .op          (q_op),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result      (m_tdata),
    .div_by_zero (m_tuser)
  );

endmodule
`default_nettype wire
